/* hdl/camera_frame_to_polar_goals_assert.svh */
// Assertion macros for the camera goal finder checker.
// Needs nothing else; included by cfpg_checker.sv.
`ifndef CAMERA_FRAME_TO_POLAR_GOALS_ASSERT_SVH
`define CAMERA_FRAME_TO_POLAR_GOALS_ASSERT_SVH
// next-cycle implication
`define CFPG_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("cfpg assertion failed");
// condition holds at every edge
`define CFPG_ASSERT_ALWAYS(lbl, ck, rn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rn) 1'b1 |-> (cond)) \
		else $error("cfpg assertion failed");
`endif

/* hdl/cfpg_pkg.sv */
// Shared constants, types and the arctangent table of the camera goal finder.
// No dependencies.
`timescale 1ns / 1ps
package cfpg_pkg;
	localparam int FRAC_BITS    = 4;
	localparam int CORDIC_STEPS = 16;
	localparam int TAB_LEN      = 24;
	localparam int CORDIC_N     = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
	localparam int ANG_FRAC     = 20;
	localparam int VEC_SHIFT    = 24;
	localparam int VEC_W        = VEC_SHIFT + 12;
	localparam int Z_W          = 32;
	localparam int SQ_W         = 17 + 2 * FRAC_BITS;
	localparam int SQ_N         = (SQ_W + 1) / 2;
	localparam int RUN_N        = (CORDIC_N > SQ_N) ? CORDIC_N : SQ_N;
	localparam int CNT_W        = $clog2(RUN_N + 1);
	localparam int TAB_IDX_W    = $clog2(TAB_LEN);
	localparam int ANG_SH       = ANG_FRAC - FRAC_BITS;
	localparam logic [7:0] NO_GOAL = 8'd255;

	localparam logic [1:0] REG_ATTACK_BLUE   = 2'd0;
	localparam logic [1:0] REG_HEADER_FIRST  = 2'd1;
	localparam logic [1:0] REG_HEADER_SECOND = 2'd2;
	localparam logic [1:0] REG_CENTRE_OFFSET = 2'd3;

	typedef struct packed {
		logic       done;
		logic [7:0] c0;
		logic [7:0] c1;
		logic [7:0] c2;
		logic [7:0] c3;
	} cfpg_frame_t;

	typedef struct packed {
		logic               done;
		logic signed [13:0] angle;
		logic [12:0]        distance;
	} cfpg_polar_t;

	// atan(2^-i) in degrees * 2^20
	function automatic logic signed [Z_W-1:0] atan_tab(input logic [TAB_IDX_W-1:0] i);
		logic signed [Z_W-1:0] v;
		unique case (i)
			5'd0:  v = 32'sd47185920;
			5'd1:  v = 32'sd27855475;
			5'd2:  v = 32'sd14718068;
			5'd3:  v = 32'sd7471121;
			5'd4:  v = 32'sd3750058;
			5'd5:  v = 32'sd1876857;
			5'd6:  v = 32'sd938658;
			5'd7:  v = 32'sd469357;
			5'd8:  v = 32'sd234682;
			5'd9:  v = 32'sd117342;
			5'd10: v = 32'sd58671;
			5'd11: v = 32'sd29335;
			5'd12: v = 32'sd14668;
			5'd13: v = 32'sd7334;
			5'd14: v = 32'sd3667;
			5'd15: v = 32'sd1833;
			5'd16: v = 32'sd917;
			5'd17: v = 32'sd458;
			5'd18: v = 32'sd229;
			5'd19: v = 32'sd115;
			5'd20: v = 32'sd57;
			5'd21: v = 32'sd29;
			5'd22: v = 32'sd14;
			5'd23: v = 32'sd7;
			default: v = '0;
		endcase
		return v;
	endfunction
endpackage

/* hdl/cfpg_parser.sv */
// Frame header hunt and coordinate byte collection.
// Depends on cfpg_pkg.
`timescale 1ns / 1ps
module cfpg_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [7:0]           rx_byte,
	input  logic [7:0]           header_first,
	input  logic [7:0]           header_second,
	output cfpg_pkg::cfpg_frame_t frame
);
	typedef enum logic [2:0] {
		PH_HUNT, PH_HDR2, PH_C0, PH_C1, PH_C2, PH_C3
	} phase_t;

	phase_t     phase_q;
	logic       done_q;
	logic [7:0] c0_q, c1_q, c2_q, c3_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			done_q  <= 1'b0;
		end else begin
			done_q <= take && (phase_q == PH_C3);
			if (take) begin
				unique case (phase_q)
					PH_HDR2: begin
						if (rx_byte == header_second)
							phase_q <= PH_C0;
						else if (rx_byte == header_first)
							phase_q <= PH_HDR2;
						else
							phase_q <= PH_HUNT;
					end
					PH_C0: phase_q <= PH_C1;
					PH_C1: phase_q <= PH_C2;
					PH_C2: phase_q <= PH_C3;
					PH_C3: phase_q <= PH_HUNT;
					default: phase_q <= (rx_byte == header_first) ? PH_HDR2 : PH_HUNT;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (phase_q == PH_C0) c0_q <= rx_byte;
			if (phase_q == PH_C1) c1_q <= rx_byte;
			if (phase_q == PH_C2) c2_q <= rx_byte;
			if (phase_q == PH_C3) c3_q <= rx_byte;
		end
	end

	assign frame = '{done: done_q, c0: c0_q, c1: c1_q, c2: c2_q, c3: c3_q};
endmodule

/* hdl/cfpg_polar.sv */
// Iterative polar unit: CORDIC bearing and digit-serial square root.
// Depends on cfpg_pkg.
`timescale 1ns / 1ps
module cfpg_polar (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [8:0]    x,
	input  logic signed [8:0]    y,
	output cfpg_pkg::cfpg_polar_t res
);
	localparam int VW = cfpg_pkg::VEC_W;
	localparam int ZW = cfpg_pkg::Z_W;
	localparam int QW = 2 * cfpg_pkg::SQ_N;
	localparam int RW = cfpg_pkg::SQ_N;
	localparam logic signed [ZW-1:0] UNIT90  = ZW'(90 * (1 << cfpg_pkg::ANG_FRAC));
	localparam logic signed [ZW-1:0] UNIT180 = ZW'(180 * (1 << cfpg_pkg::ANG_FRAC));

	logic                        busy_q, done_q, orig_q;
	logic [cfpg_pkg::CNT_W-1:0]  cnt_q;
	logic signed [VW-1:0]        cx_q, cy_q;
	logic signed [ZW-1:0]        z_q;
	logic [QW-1:0]               q_q;
	logic [RW+1:0]               rem_q;
	logic [RW-1:0]               root_q;
	logic signed [13:0]          angle_q;
	logic [12:0]                 dist_q;

	logic signed [9:0]  x10, y10, sx, sy;
	logic [17:0]        sumsq;
	logic signed [VW-1:0] dx, dy;
	logic [RW+1:0]      rem_sh, trial;
	logic signed [ZW:0] a_full, a_rnd, a_sh;
	logic [RW:0]        root_r;

	always_comb begin
		x10 = 10'(x);
		y10 = 10'(y);
		sx = x[8] ? -x10 : x10;
		sy = x[8] ? -y10 : y10;
		sumsq = 18'(x * x) + 18'(y * y);
		dx = cy_q >>> cnt_q;
		dy = cx_q >>> cnt_q;
		rem_sh = {rem_q[RW-1:0], q_q[QW-1 -: 2]};
		trial = {root_q, 2'b01};
		a_full = orig_q ? (ZW+1)'(UNIT90) : (ZW+1)'(UNIT90) - (ZW+1)'(z_q);
		a_rnd = a_full + (ZW+1)'(1 << (cfpg_pkg::ANG_SH - 1));
		a_sh = a_rnd >>> cfpg_pkg::ANG_SH;
		root_r = (rem_q > (RW+2)'(root_q)) ? (RW+1)'(root_q) + 1'b1 : (RW+1)'(root_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == cfpg_pkg::CNT_W'(cfpg_pkg::RUN_N));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == cfpg_pkg::CNT_W'(cfpg_pkg::RUN_N))
					busy_q <= 1'b0;
				else
					cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			orig_q <= (x == 9'sd0) && (y == 9'sd0);
			cx_q   <= {{(VW-10-cfpg_pkg::VEC_SHIFT){sx[9]}}, sx, {cfpg_pkg::VEC_SHIFT{1'b0}}};
			cy_q   <= {{(VW-10-cfpg_pkg::VEC_SHIFT){sy[9]}}, sy, {cfpg_pkg::VEC_SHIFT{1'b0}}};
			z_q    <= !x[8] ? '0 : (!y[8] ? UNIT180 : -UNIT180);
			q_q    <= QW'({sumsq, {(2*cfpg_pkg::FRAC_BITS){1'b0}}});
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			if (cnt_q < cfpg_pkg::CNT_W'(cfpg_pkg::CORDIC_N)) begin
				if (!cy_q[VW-1]) begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					z_q  <= z_q + cfpg_pkg::atan_tab(cnt_q[cfpg_pkg::TAB_IDX_W-1:0]);
				end else begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					z_q  <= z_q - cfpg_pkg::atan_tab(cnt_q[cfpg_pkg::TAB_IDX_W-1:0]);
				end
			end
			if (cnt_q < cfpg_pkg::CNT_W'(cfpg_pkg::SQ_N)) begin
				q_q <= {q_q[QW-3:0], 2'b00};
				if (rem_sh >= trial) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[RW-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[RW-2:0], 1'b0};
				end
			end
			if (cnt_q == cfpg_pkg::CNT_W'(cfpg_pkg::RUN_N)) begin
				if (a_sh < -(ZW+1)'(8192))
					angle_q <= -14'sd8192;
				else if (a_sh > (ZW+1)'(8191))
					angle_q <= 14'sd8191;
				else
					angle_q <= a_sh[13:0];
				dist_q <= (root_r > (RW+1)'(8191)) ? 13'd8191 : root_r[12:0];
			end
		end
	end

	assign res = '{done: done_q, angle: angle_q, distance: dist_q};
endmodule

/* hdl/camera_frame_to_polar_goals.sv */
// Camera goal finder top level: byte stream in, goal bearings and distances out.
// Depends on cfpg_pkg, cfpg_parser, cfpg_polar.
//
// Use: camera link bytes enter on s_tvalid/s_tready/s_tdata, one request per byte.
// After the header pair and four coordinate bytes (yellow x, y, blue x, y) one
// result request leaves on m_tvalid/m_tready/m_tdata. Registers are written on
// cfg_we with cfg_addr/cfg_wdata; the user must do so only while the block is idle,
// which the block does not enforce. Header and coordinate bytes are taken while
// s_tready is high. The last coordinate byte starts two passes of the shared polar
// unit, in which the CORDIC and root iterations run one step a cycle; s_tready
// stays low until the result has moved to the output register, so the block takes
// no byte of a following frame before then.
// A result waiting in the output register does not block input; a following
// frame waits in the unit until the receiver takes the earlier result.
// Reset clears the header hunt, the output valid and the registers to their
// defaults (centre offset 60).
`timescale 1ns / 1ps
module camera_frame_to_polar_goals (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// attack_angle, attack_distance, defend_angle, defend_distance,
	// attack_visible, defend_visible
	output logic [55:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [7:0]  cfg_wdata
);
	typedef enum logic [1:0] {ST_IDLE, ST_GOAL_A, ST_GOAL_B, ST_DONE} state_t;

	state_t               state_q;
	logic                 attack_blue_q;
	logic [7:0]           header_first_q, header_second_q, centre_offset_q;
	logic                 start_q, m_tvalid_q;
	logic signed [8:0]    eng_x_q, eng_y_q, def_x_q, def_y_q;
	logic                 att_vis_q, def_vis_q;
	logic signed [13:0]   att_ang_q;
	logic [12:0]          att_dist_q;
	logic [55:0]          m_tdata_q;

	cfpg_pkg::cfpg_frame_t frame;
	cfpg_pkg::cfpg_polar_t pol;
	logic                 take;
	logic signed [8:0]    yx, yy, bx, by, ax, ay, dxs, dys;

	function automatic logic signed [8:0] coord(input logic [7:0] rx, input logic [7:0] c,
			input logic [7:0] off);
		logic signed [8:0] v;
		v = (rx == cfpg_pkg::NO_GOAL) ? $signed({1'b0, c}) : $signed({1'b0, c} - {1'b0, off});
		return v;
	endfunction

	assign s_tready = (state_q == ST_IDLE) && !frame.done;
	assign take = s_tvalid && s_tready;

	cfpg_parser u_parser (
		.clk(clk), .arst_n(arst_n), .take(take), .rx_byte(s_tdata),
		.header_first(header_first_q), .header_second(header_second_q), .frame(frame)
	);

	cfpg_polar u_polar (
		.clk(clk), .arst_n(arst_n), .start(start_q), .x(eng_x_q), .y(eng_y_q), .res(pol)
	);

	always_comb begin
		yx = coord(frame.c0, frame.c0, centre_offset_q);
		yy = coord(frame.c0, frame.c1, centre_offset_q);
		bx = coord(frame.c2, frame.c2, centre_offset_q);
		by = coord(frame.c2, frame.c3, centre_offset_q);
		ax  = attack_blue_q ? bx : yx;
		ay  = attack_blue_q ? by : yy;
		dxs = attack_blue_q ? yx : bx;
		dys = attack_blue_q ? yy : by;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_blue_q   <= 1'b0;
			header_first_q  <= 8'd0;
			header_second_q <= 8'd0;
			centre_offset_q <= 8'd60;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				cfpg_pkg::REG_ATTACK_BLUE:   attack_blue_q   <= cfg_wdata[0];
				cfpg_pkg::REG_HEADER_FIRST:  header_first_q  <= cfg_wdata;
				cfpg_pkg::REG_HEADER_SECOND: header_second_q <= cfg_wdata;
				cfpg_pkg::REG_CENTRE_OFFSET: centre_offset_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			start_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata    <= '0;
		end else begin
			start_q <= ((state_q == ST_IDLE) && frame.done) ||
				((state_q == ST_GOAL_A) && pol.done);
			if ((state_q == ST_DONE) && (!m_tvalid_q || m_tready))
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (frame.done) begin
						eng_x_q   <= ax;
						eng_y_q   <= ay;
						def_x_q   <= dxs;
						def_y_q   <= dys;
						att_vis_q <= (ay != 9'sd255);
						def_vis_q <= (dys != 9'sd255);
						state_q   <= ST_GOAL_A;
					end
				end
				ST_GOAL_A: begin
					if (pol.done) begin
						att_ang_q  <= pol.angle;
						att_dist_q <= pol.distance;
						eng_x_q    <= def_x_q;
						eng_y_q    <= def_y_q;
						state_q    <= ST_GOAL_B;
					end
				end
				ST_GOAL_B: begin
					if (pol.done) begin
						m_tdata_q <= {def_vis_q, att_vis_q, pol.distance, pol.angle,
							att_dist_q, att_ang_q};
						state_q   <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tdata <= m_tdata_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
endmodule

/* hdl/cfpg_checker.sv */
// Port-level checker for the camera goal finder, bound to the top level.
// Depends on camera_frame_to_polar_goals_assert.svh.
`timescale 1ns / 1ps
`include "camera_frame_to_polar_goals_assert.svh"
module cfpg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);
	`CFPG_ASSERT_NEXT(a_valid_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`CFPG_ASSERT_NEXT(a_data_hold, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))
	`CFPG_ASSERT_ALWAYS(a_att_dist, clk, arst_n, !m_tvalid || (m_tdata[26:14] <= 13'd5770))
	`CFPG_ASSERT_ALWAYS(a_def_dist, clk, arst_n, !m_tvalid || (m_tdata[53:41] <= 13'd5770))
endmodule

bind camera_frame_to_polar_goals cfpg_checker u_cfpg_checker (.*);

/* dv/camera_frame_to_polar_goals_tb.sv */
// Self-checking testbench for camera_frame_to_polar_goals: byte stream in, goal polar result out.
// Depends on cfpg_pkg and the block; predicts each result with its own CORDIC and root.
`timescale 1ns / 1ps
module camera_frame_to_polar_goals_tb;
	typedef struct {
		logic signed [13:0] att_ang;
		logic [12:0]        att_dist;
		logic signed [13:0] def_ang;
		logic [12:0]        def_dist;
		logic               att_vis;
		logic               def_vis;
	} goals_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = '0;
	logic [7:0]  cfg_wdata = '0;

	camera_frame_to_polar_goals uut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	logic       p_attack_blue = 1'b0;
	logic [7:0] p_hdr1 = 8'd0;
	logic [7:0] p_hdr2 = 8'd0;
	logic [7:0] p_offset = 8'd60;
	int         p_phase = 0;
	logic [7:0] p_coords [4];

	goals_t expected_goals [$];
	int     errors = 0;
	int     frames_seen = 0;
	int     bytes_sent = 0;
	int     hold_cycles = 0;
	int     burst_left = 0;

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic logic signed [13:0] goal_bearing(longint x, longint y);
		longint z, dx, dy, r;
		z = 0;
		if (x == 0 && y == 0) begin
			z = 0;
		end else begin
			if (x < 0) begin
				z = (y >= 0) ? 180 * (64'sd1 << cfpg_pkg::ANG_FRAC)
					: -180 * (64'sd1 << cfpg_pkg::ANG_FRAC);
				x = -x;
				y = -y;
			end
			x = x <<< cfpg_pkg::VEC_SHIFT;
			y = y <<< cfpg_pkg::VEC_SHIFT;
			for (int i = 0; i < cfpg_pkg::CORDIC_N; i++) begin
				dx = floor_shr(y, i);
				dy = floor_shr(x, i);
				if (y >= 0) begin
					x += dx; y -= dy;
					z += longint'(cfpg_pkg::atan_tab(i[cfpg_pkg::TAB_IDX_W-1:0]));
				end else begin
					x -= dx; y += dy;
					z -= longint'(cfpg_pkg::atan_tab(i[cfpg_pkg::TAB_IDX_W-1:0]));
				end
			end
		end
		r = 90 * (64'sd1 << cfpg_pkg::ANG_FRAC) - z;
		r = floor_shr(r + (64'sd1 << (cfpg_pkg::ANG_SH - 1)), cfpg_pkg::ANG_SH);
		if (r < -8192) r = -8192;
		if (r > 8191) r = 8191;
		return r[13:0];
	endfunction

	function automatic logic [12:0] goal_distance(longint x, longint y);
		longint q, r;
		q = (x * x + y * y) <<< (2 * cfpg_pkg::FRAC_BITS);
		r = 0;
		while ((r + 1) * (r + 1) <= q) r++;
		if (q - r * r > r) r++;
		if (r > 8191) r = 8191;
		return r[12:0];
	endfunction

	function automatic void centre_pair(logic [7:0] rx, logic [7:0] ry,
			output longint x, output longint y);
		if (rx == cfpg_pkg::NO_GOAL) begin
			x = rx; y = ry;
		end else begin
			x = longint'(rx) - longint'(p_offset);
			y = longint'(ry) - longint'(p_offset);
		end
	endfunction

	function automatic void predict_byte(logic [7:0] b);
		longint yx, yy, bx, by, ax, ay, dx, dy;
		goals_t g;
		if (p_phase == 1) begin
			p_phase = (b == p_hdr2) ? 2 : (b == p_hdr1) ? 1 : 0;
		end else if (p_phase >= 2 && p_phase <= 5) begin
			p_coords[2'(p_phase - 2)] = b;
			if (p_phase != 5) begin
				p_phase++;
			end else begin
				p_phase = 0;
				centre_pair(p_coords[0], p_coords[1], yx, yy);
				centre_pair(p_coords[2], p_coords[3], bx, by);
				if (p_attack_blue) begin
					ax = bx; ay = by; dx = yx; dy = yy;
				end else begin
					ax = yx; ay = yy; dx = bx; dy = by;
				end
				g.att_ang = goal_bearing(ax, ay);
				g.att_dist = goal_distance(ax, ay);
				g.def_ang = goal_bearing(dx, dy);
				g.def_dist = goal_distance(dx, dy);
				g.att_vis = (ay != cfpg_pkg::NO_GOAL);
				g.def_vis = (dy != cfpg_pkg::NO_GOAL);
				expected_goals.push_back(g);
			end
		end else begin
			p_phase = (b == p_hdr1) ? 1 : 0;
		end
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH frame %0d %s: got %0d want %0d", frames_seen, what, got, want);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		goals_t g;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_goals.size() == 0) begin
				report_mismatch("unexpected result", longint'(m_tdata), 64'sd0);
			end else begin
				g = expected_goals.pop_front();
				if ($signed(m_tdata[13:0]) != g.att_ang)
					report_mismatch("attack_angle", longint'($signed(m_tdata[13:0])),
						longint'(g.att_ang));
				if (m_tdata[26:14] != g.att_dist)
					report_mismatch("attack_distance", longint'(m_tdata[26:14]),
						longint'(g.att_dist));
				if ($signed(m_tdata[40:27]) != g.def_ang)
					report_mismatch("defend_angle", longint'($signed(m_tdata[40:27])),
						longint'(g.def_ang));
				if (m_tdata[53:41] != g.def_dist)
					report_mismatch("defend_distance", longint'(m_tdata[53:41]),
						longint'(g.def_dist));
				if (m_tdata[54] != g.att_vis)
					report_mismatch("attack_visible", longint'(m_tdata[54]),
						longint'(g.att_vis));
				if (m_tdata[55] != g.def_vis)
					report_mismatch("defend_visible", longint'(m_tdata[55]),
						longint'(g.def_vis));
			end
			frames_seen++;
		end
	end

	// receiver stall pattern, with a long hold-off on request
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	task automatic send_byte(logic [7:0] b, bit gaps = 1);
		int gap;
		if (gaps && burst_left == 0) begin
			gap = $urandom_range(0, 60);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_byte(b);
		bytes_sent++;
		if (burst_left > 0) burst_left--;
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_goals.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		unique case (idx)
			cfpg_pkg::REG_ATTACK_BLUE:   p_attack_blue = val[0];
			cfpg_pkg::REG_HEADER_FIRST:  p_hdr1 = val;
			cfpg_pkg::REG_HEADER_SECOND: p_hdr2 = val;
			cfpg_pkg::REG_CENTRE_OFFSET: p_offset = val;
		endcase
	endtask

	task automatic send_frame(logic [7:0] c0, c1, c2, c3);
		send_byte(p_hdr1);
		send_byte(p_hdr2);
		send_byte(c0);
		send_byte(c1);
		send_byte(c2);
		send_byte(c3);
	endtask

	task automatic set_config(logic ab, logic [7:0] h1, h2, off);
		drain();
		write_reg(cfpg_pkg::REG_ATTACK_BLUE, {7'd0, ab});
		write_reg(cfpg_pkg::REG_HEADER_FIRST, h1);
		write_reg(cfpg_pkg::REG_HEADER_SECOND, h2);
		write_reg(cfpg_pkg::REG_CENTRE_OFFSET, off);
		cfg_we <= 1'b0;
	endtask

	task automatic test_directed;
		set_config(1'b0, 8'hB7, 8'h42, 8'd60);
		send_frame(8'd60, 8'd60, 8'd255, 8'd255);   // origin and absent goal
		send_frame(8'd0, 8'd0, 8'd255, 8'd0);
		send_frame(8'd254, 8'd255, 8'd0, 8'd254);
		send_frame(8'd30, 8'd200, 8'd200, 8'd30);
		// header mismatch: repeated first byte keeps hunting second
		send_byte(8'hB7); send_byte(8'hB7); send_byte(8'h42);
		send_byte(8'd10); send_byte(8'd100); send_byte(8'd70); send_byte(8'd20);
		send_byte(8'hB7); send_byte(8'h00);   // broken header
		set_config(1'b1, 8'hFF, 8'hFF, 8'd0);
		send_frame(8'd255, 8'd255, 8'd128, 8'd0);
		send_frame(8'd0, 8'd255, 8'd254, 8'd254);
		set_config(1'b0, 8'h00, 8'h00, 8'd255);
		send_frame(8'd0, 8'd0, 8'd254, 8'd1);
	endtask

	task automatic test_random(int n_bytes);
		int stop;
		stop = bytes_sent + n_bytes;
		while (bytes_sent < stop) begin
			if ($urandom_range(0, 9) < 8)
				send_frame(8'($urandom), 8'($urandom),
					($urandom_range(0, 5) == 0) ? 8'd255 : 8'($urandom),
					($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom));
			else
				send_byte(($urandom_range(0, 1) != 0) ? p_hdr1 : 8'($urandom));
		end
	endtask

	task automatic test_backpressure;
		hold_cycles = 600;
		repeat (5) send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		set_config(1'b0, 8'h5A, 8'hA5, 8'd60);
		test_random(500);
		test_backpressure();
		set_config(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
		test_random(700);
		set_config(1'($urandom), 8'h33, 8'h33, 8'd128);
		test_random(650);
		drain();
		$display("Covered %0d bytes and %0d frames over six register settings,",
			bytes_sent, frames_seen);
		$display("including header slips, absent goals, the origin and a long output stall.");
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end
endmodule
